// ----- rtl/hsb_pkg.sv -----
// hsb_pkg: shared constants, codes and transfer structs for the shade adjust pipeline.
// No dependencies; imported by every module under rtl/.
package hsb_pkg;

  localparam int CHANNEL_BITS  = 8;
  localparam int HUE_FRAC_BITS = 8;

  localparam int CH_W   = CHANNEL_BITS;
  localparam int AMT_W  = 9;
  localparam int MODE_W = 3;
  localparam int FRAC_W = 16;
  localparam int S_W    = FRAC_W + 1;
  localparam int V_W    = CH_W + FRAC_W;
  localparam int HUE_W  = $clog2(360 << HUE_FRAC_BITS);
  localparam int Q_W    = $clog2((60 << HUE_FRAC_BITS) + 1);

  // divider: DIV_BITS quotient bits per stage
  localparam int DIV_BITS   = 4;
  localparam int DVD_RAW    = CH_W + ((FRAC_W > Q_W) ? FRAC_W : Q_W);
  localparam int DIV_STAGES = (DVD_RAW + DIV_BITS - 1) / DIV_BITS;
  localparam int DVD_W      = DIV_STAGES * DIV_BITS;

  // front register + divider + two adjust stages + four back-conversion stages
  localparam int PIPE_LAT = 1 + DIV_STAGES + 2 + 4;

  localparam logic [AMT_W-1:0] AMT_ONE = AMT_W'(256);
  localparam logic [CH_W-1:0]  CMAX    = CH_W'((1 << CHANNEL_BITS) - 1);
  localparam logic [S_W-1:0]   S_ONE   = S_W'(1 << FRAC_W);

  localparam logic [HUE_W-1:0] DEG60  = HUE_W'(60 << HUE_FRAC_BITS);
  localparam logic [HUE_W-1:0] DEG120 = HUE_W'(120 << HUE_FRAC_BITS);
  localparam logic [HUE_W-1:0] DEG180 = HUE_W'(180 << HUE_FRAC_BITS);
  localparam logic [HUE_W-1:0] DEG240 = HUE_W'(240 << HUE_FRAC_BITS);
  localparam logic [HUE_W-1:0] DEG300 = HUE_W'(300 << HUE_FRAC_BITS);
  localparam logic [HUE_W-1:0] DEG330 = HUE_W'(330 << HUE_FRAC_BITS);
  localparam logic [HUE_W-1:0] DEG360 = HUE_W'(360 << HUE_FRAC_BITS);

  // f = (hm << 16) / (15 << (HF+2)) = (hm << (14-HF)) / 15, done by reciprocal
  localparam int F_SHIFT  = 14 - HUE_FRAC_BITS;
  localparam int FX_W     = 20;
  localparam int RECIP_W  = 21;
  localparam int RECIP_SH = 24;
  localparam logic [RECIP_W-1:0] RECIP15 = RECIP_W'(1118482);

  typedef enum logic [MODE_W-1:0] {
    MODE_SHADE      = 3'd0,
    MODE_TINT       = 3'd1,
    MODE_TONE       = 3'd2,
    MODE_WARMER     = 3'd3,
    MODE_COOLER     = 3'd4,
    MODE_COMP_TINT  = 3'd5,
    MODE_COMP_SHADE = 3'd6,
    MODE_ANALOGOUS  = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_e;

  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } sector_e;

  typedef struct packed {
    logic [CH_W-1:0]  in_red;
    logic [CH_W-1:0]  in_green;
    logic [CH_W-1:0]  in_blue;
    logic [CH_W-1:0]  in_alpha;
    logic [AMT_W-1:0] amount;
  } pix_in_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_alpha;
  } pix_out_t;

  // travels alongside the dividers
  typedef struct packed {
    logic             valid;
    mode_e            mode;
    logic [AMT_W-1:0] amt;
    logic [CH_W-1:0]  alpha;
    logic [CH_W-1:0]  mx;
    logic             grey;
    chan_e            sel;
    logic             neg;
  } side_t;

  typedef struct packed {
    logic             valid;
    logic [CH_W-1:0]  alpha;
    logic [HUE_W-1:0] hue;
    logic [S_W-1:0]   sat;
    logic [V_W-1:0]   val;
  } hsv_t;

endpackage

// ----- rtl/hsb_div.sv -----
// hsb_div: pipelined restoring divider, DIV_BITS quotient bits per stage.
// Depends on hsb_pkg.
module hsb_div (
  input  logic                     clk_i,
  input  logic [hsb_pkg::DVD_W-1:0] dividend_i,
  input  logic [hsb_pkg::CH_W-1:0]  divisor_i,
  output logic [hsb_pkg::DVD_W-1:0] quotient_o
);
  import hsb_pkg::*;

  logic [CH_W-1:0]  rem_q [DIV_STAGES];
  logic [DVD_W-1:0] num_q [DIV_STAGES];
  logic [CH_W-1:0]  dsr_q [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [CH_W-1:0]  rem_in;
    logic [DVD_W-1:0] num_in;
    logic [CH_W-1:0]  dsr_in;
    logic [CH_W-1:0]  rem_nx;
    logic [DVD_W-1:0] num_nx;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = dividend_i;
      assign dsr_in = divisor_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign num_in = num_q[k-1];
      assign dsr_in = dsr_q[k-1];
    end

    // dividend bits leave at the top, quotient bits enter at the bottom
    always_comb begin
      logic [CH_W:0] r;
      rem_nx = rem_in;
      num_nx = num_in;
      for (int j = 0; j < DIV_BITS; j++) begin
        r      = {rem_nx, num_nx[DVD_W-1]};
        num_nx = {num_nx[DVD_W-2:0], 1'b0};
        if (r >= {1'b0, dsr_in}) begin
          r         = r - {1'b0, dsr_in};
          num_nx[0] = 1'b1;
        end
        rem_nx = r[CH_W-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= rem_nx;
      num_q[k] <= num_nx;
      dsr_q[k] <= dsr_in;
    end
  end

  assign quotient_o = num_q[DIV_STAGES-1];

endmodule

// ----- rtl/hsb_adjust.sv -----
// hsb_adjust: forms hue from the divider term and applies the mode to H, S and V.
// Two register stages. Depends on hsb_pkg.
module hsb_adjust (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  hsb_pkg::side_t            side_i,
  input  logic [hsb_pkg::DVD_W-1:0] sat_quo_i,
  input  logic [hsb_pkg::DVD_W-1:0] hue_quo_i,
  output hsb_pkg::hsv_t             hsv_o
);
  import hsb_pkg::*;

  typedef struct packed {
    logic             valid;
    mode_e            mode;
    logic [AMT_W-1:0] amt;
    logic [CH_W-1:0]  alpha;
    logic [HUE_W-1:0] hue;
    logic [S_W-1:0]   sat;
    logic [V_W-1:0]   val;
  } adj_t;

  adj_t adj_d, adj_q;
  hsv_t hsv_d, hsv_q;

  logic [Q_W-1:0]           qterm;
  logic [S_W-1:0]           sat0;
  logic [CH_W+AMT_W-1:0]    shade_prod;
  logic [CH_W+AMT_W-1:0]    tint_prod;
  logic [S_W+AMT_W:0]       s_tint_prod;
  logic [S_W+AMT_W-1:0]     s_tone_prod;
  logic [V_W-1:0]           v_shade, v_tint;
  logic [S_W-1:0]           s_tint, s_tone;

  // stage 1: hue from sector base, saturation and brightness scaling
  always_comb begin
    qterm = side_i.grey ? '0 : hue_quo_i[Q_W-1:0];
    sat0  = side_i.grey ? '0 : sat_quo_i[S_W-1:0];

    shade_prod  = (CH_W+AMT_W)'(side_i.mx) * (CH_W+AMT_W)'(AMT_ONE - side_i.amt);
    tint_prod   = (CH_W+AMT_W)'(CMAX - side_i.mx) * (CH_W+AMT_W)'(side_i.amt);
    s_tint_prod = (S_W+AMT_W+1)'(sat0) * (S_W+AMT_W+1)'({1'b0, AMT_ONE, 1'b0}
                  - {1'b0, side_i.amt});
    s_tone_prod = (S_W+AMT_W)'(sat0) * (S_W+AMT_W)'(AMT_ONE - side_i.amt);

    v_shade = V_W'({shade_prod, 8'b0});
    v_tint  = V_W'({side_i.mx, 16'b0}) + V_W'({tint_prod, 8'b0});
    s_tint  = S_W'(s_tint_prod >> 9);
    s_tone  = S_W'(s_tone_prod >> 8);

    adj_d.valid = side_i.valid;
    adj_d.mode  = side_i.mode;
    adj_d.amt   = side_i.amt;
    adj_d.alpha = side_i.alpha;

    case (side_i.sel)
      CH_RED:   adj_d.hue = side_i.neg ? DEG360 - HUE_W'(qterm) : HUE_W'(qterm);
      CH_GREEN: adj_d.hue = side_i.neg ? DEG120 - HUE_W'(qterm) : DEG120 + HUE_W'(qterm);
      CH_BLUE:  adj_d.hue = side_i.neg ? DEG240 - HUE_W'(qterm) : DEG240 + HUE_W'(qterm);
      default:  adj_d.hue = '0;
    endcase
    if (side_i.grey) begin
      adj_d.hue = '0;
    end

    adj_d.sat = sat0;
    adj_d.val = V_W'({side_i.mx, 16'b0});
    case (side_i.mode)
      MODE_SHADE, MODE_COMP_SHADE: begin
        adj_d.val = v_shade;
      end
      MODE_TINT, MODE_COMP_TINT: begin
        adj_d.val = v_tint;
        adj_d.sat = s_tint;
      end
      MODE_TONE: begin
        adj_d.sat = s_tone;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adj_q <= '0;
    end else begin
      adj_q <= adj_d;
    end
  end

  // stage 2: hue rotation with wrap into [0, 360)
  logic [31:0]      d30_w, d60_w;
  logic [HUE_W-1:0] d30, d60;
  logic [HUE_W:0]   hsum;

  always_comb begin
    d30_w = ((32'(adj_q.amt) * 32'd30) << HUE_FRAC_BITS) >> 8;
    d60_w = ((32'(adj_q.amt) * 32'd60) << HUE_FRAC_BITS) >> 8;
    d30   = HUE_W'(d30_w);
    d60   = HUE_W'(d60_w);

    case (adj_q.mode)
      MODE_WARMER:     hsum = {1'b0, adj_q.hue} + {1'b0, DEG360} - {1'b0, d30};
      MODE_COOLER:     hsum = {1'b0, adj_q.hue} + {1'b0, d30};
      MODE_COMP_TINT,
      MODE_COMP_SHADE: hsum = {1'b0, adj_q.hue} + {1'b0, DEG180};
      MODE_ANALOGOUS:  hsum = {1'b0, adj_q.hue} + {1'b0, d60} + {1'b0, DEG330};
      default:         hsum = {1'b0, adj_q.hue};
    endcase
    // analogous can reach past twice the full turn minus a little: two passes
    if (hsum >= {1'b0, DEG360}) begin
      hsum = hsum - {1'b0, DEG360};
    end
    if (hsum >= {1'b0, DEG360}) begin
      hsum = hsum - {1'b0, DEG360};
    end

    hsv_d.valid = adj_q.valid;
    hsv_d.alpha = adj_q.alpha;
    hsv_d.hue   = hsum[HUE_W-1:0];
    hsv_d.sat   = adj_q.sat;
    hsv_d.val   = adj_q.val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hsv_q <= '0;
    end else begin
      hsv_q <= hsv_d;
    end
  end

  assign hsv_o = hsv_q;

endmodule

// ----- rtl/hsb_hsv2rgb.sv -----
// hsb_hsv2rgb: sector split, fraction, p/q/t products and channel selection.
// Four register stages, the last one is the output register. Depends on hsb_pkg.
module hsb_hsv2rgb (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hsb_pkg::hsv_t     hsv_i,
  output logic              valid_o,
  output hsb_pkg::pix_out_t pix_o
);
  import hsb_pkg::*;

  typedef struct packed {
    logic             valid;
    logic [CH_W-1:0]  alpha;
    sector_e          sector;
    logic [HUE_W-1:0] hm;
    logic [S_W-1:0]   sat;
    logic [V_W-1:0]   val;
  } b1_t;

  typedef struct packed {
    logic              valid;
    logic [CH_W-1:0]   alpha;
    sector_e           sector;
    logic [FRAC_W-1:0] f;
    logic [S_W-1:0]    sat;
    logic [V_W-1:0]    val;
  } b2_t;

  typedef struct packed {
    logic            valid;
    logic [CH_W-1:0] alpha;
    sector_e         sector;
    logic [S_W-1:0]  kp;
    logic [S_W-1:0]  kq;
    logic [S_W-1:0]  kt;
    logic [V_W-1:0]  val;
  } b3_t;

  b1_t b1_d, b1_q;
  b2_t b2_d, b2_q;
  b3_t b3_d, b3_q;
  logic     valid_d, valid_q;
  pix_out_t pix_d, pix_q;

  // stage 1: sector and remainder within the sector
  always_comb begin
    b1_d.valid = hsv_i.valid;
    b1_d.alpha = hsv_i.alpha;
    b1_d.sat   = hsv_i.sat;
    b1_d.val   = hsv_i.val;
    if (hsv_i.hue >= DEG300) begin
      b1_d.sector = SEC_5;
      b1_d.hm     = hsv_i.hue - DEG300;
    end else if (hsv_i.hue >= DEG240) begin
      b1_d.sector = SEC_4;
      b1_d.hm     = hsv_i.hue - DEG240;
    end else if (hsv_i.hue >= DEG180) begin
      b1_d.sector = SEC_3;
      b1_d.hm     = hsv_i.hue - DEG180;
    end else if (hsv_i.hue >= DEG120) begin
      b1_d.sector = SEC_2;
      b1_d.hm     = hsv_i.hue - DEG120;
    end else if (hsv_i.hue >= DEG60) begin
      b1_d.sector = SEC_1;
      b1_d.hm     = hsv_i.hue - DEG60;
    end else begin
      b1_d.sector = SEC_0;
      b1_d.hm     = hsv_i.hue;
    end
  end

  // stage 2: f in Q16 by reciprocal multiply
  logic [FX_W-1:0]         fx;
  logic [FX_W+RECIP_W-1:0] f_prod;

  always_comb begin
    fx          = FX_W'(b1_q.hm) << F_SHIFT;
    f_prod      = (FX_W+RECIP_W)'(fx) * (FX_W+RECIP_W)'(RECIP15);
    b2_d.valid  = b1_q.valid;
    b2_d.alpha  = b1_q.alpha;
    b2_d.sector = b1_q.sector;
    b2_d.f      = f_prod[RECIP_SH +: FRAC_W];
    b2_d.sat    = b1_q.sat;
    b2_d.val    = b1_q.val;
  end

  // stage 3: scale factors 1-S, 1-S*f, 1-S*(1-f)
  logic [2*S_W-1:0] sf_prod, sg_prod;

  always_comb begin
    sf_prod     = (2*S_W)'(b2_q.sat) * (2*S_W)'(b2_q.f);
    sg_prod     = (2*S_W)'(b2_q.sat) * (2*S_W)'(S_ONE - S_W'(b2_q.f));
    b3_d.valid  = b2_q.valid;
    b3_d.alpha  = b2_q.alpha;
    b3_d.sector = b2_q.sector;
    b3_d.kp     = S_ONE - b2_q.sat;
    b3_d.kq     = S_ONE - sf_prod[FRAC_W +: S_W];
    b3_d.kt     = S_ONE - sg_prod[FRAC_W +: S_W];
    b3_d.val    = b2_q.val;
  end

  // stage 4: p, q, t and channel pick
  logic [V_W+S_W-1:0] p_prod, q_prod, t_prod;
  logic [CH_W-1:0]    cv, cp, cq, ct;

  always_comb begin
    p_prod = (V_W+S_W)'(b3_q.val) * (V_W+S_W)'(b3_q.kp);
    q_prod = (V_W+S_W)'(b3_q.val) * (V_W+S_W)'(b3_q.kq);
    t_prod = (V_W+S_W)'(b3_q.val) * (V_W+S_W)'(b3_q.kt);
    cv     = b3_q.val[FRAC_W +: CH_W];
    cp     = p_prod[2*FRAC_W +: CH_W];
    cq     = q_prod[2*FRAC_W +: CH_W];
    ct     = t_prod[2*FRAC_W +: CH_W];

    valid_d         = b3_q.valid;
    pix_d.out_alpha = b3_q.alpha;
    case (b3_q.sector)
      SEC_0: begin
        pix_d.out_red = cv; pix_d.out_green = ct; pix_d.out_blue = cp;
      end
      SEC_1: begin
        pix_d.out_red = cq; pix_d.out_green = cv; pix_d.out_blue = cp;
      end
      SEC_2: begin
        pix_d.out_red = cp; pix_d.out_green = cv; pix_d.out_blue = ct;
      end
      SEC_3: begin
        pix_d.out_red = cp; pix_d.out_green = cq; pix_d.out_blue = cv;
      end
      SEC_4: begin
        pix_d.out_red = ct; pix_d.out_green = cp; pix_d.out_blue = cv;
      end
      default: begin
        pix_d.out_red = cv; pix_d.out_green = cp; pix_d.out_blue = cq;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_q    <= '0;
      b2_q    <= '0;
      b3_q    <= '0;
      valid_q <= 1'b0;
    end else begin
      b1_q    <= b1_d;
      b2_q    <= b2_d;
      b3_q    <= b3_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
  end

  assign valid_o = valid_q;
  assign pix_o   = pix_q;

endmodule

// ----- rtl/hsb_shade_adjust_pixel.sv -----
// hsb_shade_adjust_pixel: RGB -> HSV, mode adjust, HSV -> RGB, one pixel per clock.
// Depends on hsb_pkg, hsb_div, hsb_adjust, hsb_hsv2rgb.
// Start passes the front register, dividers, adjust and hsb_hsv2rgb; one transfer
// per cycle, set by the fully pipelined dividers (4 quotient bits per stage).
// Results cannot be stalled, so busy never rises. Reset clears mode and valid bits.
module hsb_shade_adjust_pixel (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  hsb_pkg::pix_in_t                pix_i,
  input  logic                            cfg_we_i,
  input  logic [hsb_pkg::MODE_W-1:0]      cfg_wdata_i,
  output logic                            result_valid_o,
  output hsb_pkg::pix_out_t               pix_o
);
  import hsb_pkg::*;

  // no back-pressure anywhere in the pipe
  assign busy = 1'b0;

  mode_e mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SHADE;
    end else if (cfg_we_i) begin
      mode_q <= mode_e'(cfg_wdata_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Front: max, min, spread and the hue difference term
  // ---------------------------------------------------------------------------
  logic [CH_W-1:0]  r, g, b, mx, mn, delta, diff;
  logic [AMT_W-1:0] amt;
  side_t            side_d, side0_q;
  logic [DVD_W-1:0] dvd_s_d, dvd_h_d, dvd_s_q, dvd_h_q;
  logic [CH_W-1:0]  mx_q, delta_q;

  always_comb begin
    r   = pix_i.in_red;
    g   = pix_i.in_green;
    b   = pix_i.in_blue;
    amt = (pix_i.amount > AMT_ONE) ? AMT_ONE : pix_i.amount;

    mx = (r > g) ? r : g;
    if (b > mx) begin
      mx = b;
    end
    mn = (r < g) ? r : g;
    if (b < mn) begin
      mn = b;
    end
    delta = mx - mn;

    side_d.valid = start && !busy;
    side_d.mode  = mode_q;
    side_d.amt   = amt;
    side_d.alpha = pix_i.in_alpha;
    side_d.mx    = mx;
    side_d.grey  = (delta == '0);

    // ties resolve red first, then green
    if (r == mx) begin
      side_d.sel = CH_RED;
      side_d.neg = (g < b);
      diff       = (g >= b) ? g - b : b - g;
    end else if (g == mx) begin
      side_d.sel = CH_GREEN;
      side_d.neg = (b < r);
      diff       = (b >= r) ? b - r : r - b;
    end else begin
      side_d.sel = CH_BLUE;
      side_d.neg = (r < g);
      diff       = (r >= g) ? r - g : g - r;
    end

    dvd_s_d = DVD_W'(delta) << FRAC_W;
    dvd_h_d = DVD_W'(diff) * DVD_W'(DEG60);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side0_q <= '0;
    end else begin
      side0_q <= side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_s_q <= dvd_s_d;
    dvd_h_q <= dvd_h_d;
    mx_q    <= mx;
    delta_q <= delta;
  end

  // ---------------------------------------------------------------------------
  // Dividers: S = (delta << 16) / max and the hue term diff*60deg / delta.
  // Side data rides a matching delay line.
  // ---------------------------------------------------------------------------
  logic [DVD_W-1:0] sat_quo, hue_quo;
  side_t            side_line_q [DIV_STAGES];

  hsb_div u_div_sat (
    .clk_i      (clk_i),
    .dividend_i (dvd_s_q),
    .divisor_i  (mx_q),
    .quotient_o (sat_quo)
  );

  hsb_div u_div_hue (
    .clk_i      (clk_i),
    .dividend_i (dvd_h_q),
    .divisor_i  (delta_q),
    .quotient_o (hue_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        side_line_q[k] <= '0;
      end
    end else begin
      side_line_q[0] <= side0_q;
      for (int k = 1; k < DIV_STAGES; k++) begin
        side_line_q[k] <= side_line_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Mode adjust and conversion back to RGB
  // ---------------------------------------------------------------------------
  hsv_t hsv;

  hsb_adjust u_adjust (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .side_i    (side_line_q[DIV_STAGES-1]),
    .sat_quo_i (sat_quo),
    .hue_quo_i (hue_quo),
    .hsv_o     (hsv)
  );

  hsb_hsv2rgb u_hsv2rgb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .hsv_i   (hsv),
    .valid_o (result_valid_o),
    .pix_o   (pix_o)
  );

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##PIPE_LAT result_valid_o)
    else $error("accepted transfer produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start, PIPE_LAT))
    else $error("result without an accepted transfer");

  a_alpha_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> pix_o.out_alpha == $past(pix_i.in_alpha, PIPE_LAT))
    else $error("alpha altered in the pipe");

endmodule

// ----- tb/hsb_shade_adjust_pixel_chk.sv -----
// Checker for hsb_shade_adjust_pixel: predicts each pixel transfer and compares the results.
// Depends on hsb_pkg; instantiated by hsb_shade_adjust_pixel_tb.
`timescale 1ns / 1ps

module hsb_shade_adjust_pixel_chk
  import hsb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic                busy,
  input  pix_in_t             pix_i,
  input  logic                cfg_we_i,
  input  logic [MODE_W-1:0]   cfg_wdata_i,
  input  logic                result_valid_o,
  input  pix_out_t            pix_o,
  output int                  fail_cnt,
  output int                  pending_cnt
);

  localparam longint unsigned HDEG = 1 << HUE_FRAC_BITS;

  mode_e     cur_mode;
  pix_out_t  pixel_q[$];

  function automatic longint unsigned hue_wrap(longint unsigned h);
    while (h >= 360 * HDEG) h -= 360 * HDEG;
    return h;
  endfunction

  function automatic pix_out_t shade_pixel(pix_in_t px, mode_e md);
    longint unsigned r, g, b, a, mx, mn, dl, h, s, v, d, sec, f, p, q, t;
    longint unsigned ro, go, bo;
    pix_out_t res;
    r = px.in_red; g = px.in_green; b = px.in_blue;
    a = px.amount;
    if (a > 256) a = 256;
    mx = (r > g) ? r : g;
    if (b > mx) mx = b;
    mn = (r < g) ? r : g;
    if (b < mn) mn = b;
    dl = mx - mn;
    v = mx << 16;
    h = 0; s = 0;
    if (mx != 0 && dl != 0) begin
      s = (dl << 16) / mx;
      if (r == mx) begin
        h = (g >= b) ? ((g - b) * 60 * HDEG) / dl : 360 * HDEG - ((b - g) * 60 * HDEG) / dl;
      end else if (g == mx) begin
        h = (b >= r) ? 120 * HDEG + ((b - r) * 60 * HDEG) / dl
                     : 120 * HDEG - ((r - b) * 60 * HDEG) / dl;
      end else begin
        h = (r >= g) ? 240 * HDEG + ((r - g) * 60 * HDEG) / dl
                     : 240 * HDEG - ((g - r) * 60 * HDEG) / dl;
      end
      h = hue_wrap(h);
    end
    case (md)
      MODE_SHADE: v = (v * (256 - a)) >> 8;
      MODE_TINT: begin
        v = v + ((((longint'(CMAX)) << 16) - v) * a >> 8);
        s = (s * (512 - a)) >> 9;
      end
      MODE_TONE: s = (s * (256 - a)) >> 8;
      MODE_WARMER: begin
        d = (30 * a * HDEG) >> 8;
        h = hue_wrap(h + 360 * HDEG - d);
      end
      MODE_COOLER: begin
        d = (30 * a * HDEG) >> 8;
        h = hue_wrap(h + d);
      end
      MODE_COMP_TINT: begin
        h = hue_wrap(h + 180 * HDEG);
        v = v + ((((longint'(CMAX)) << 16) - v) * a >> 8);
        s = (s * (512 - a)) >> 9;
      end
      MODE_COMP_SHADE: begin
        h = hue_wrap(h + 180 * HDEG);
        v = (v * (256 - a)) >> 8;
      end
      default: begin
        d = (60 * a * HDEG) >> 8;
        h = hue_wrap(h + d + 330 * HDEG);
      end
    endcase
    if (s == 0) begin
      ro = v; go = v; bo = v;
    end else begin
      sec = h / (60 * HDEG);
      f = ((h % (60 * HDEG)) << 16) / (60 * HDEG);
      p = (v * (65536 - s)) >> 16;
      q = (v * (65536 - ((s * f) >> 16))) >> 16;
      t = (v * (65536 - ((s * (65536 - f)) >> 16))) >> 16;
      case (sec)
        0: begin ro = v; go = t; bo = p; end
        1: begin ro = q; go = v; bo = p; end
        2: begin ro = p; go = v; bo = t; end
        3: begin ro = p; go = q; bo = v; end
        4: begin ro = t; go = p; bo = v; end
        default: begin ro = v; go = p; bo = q; end
      endcase
    end
    res.out_red   = CH_W'(ro >> 16);
    res.out_green = CH_W'(go >> 16);
    res.out_blue  = CH_W'(bo >> 16);
    res.out_alpha = px.in_alpha;
    return res;
  endfunction

  assign pending_cnt = pixel_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    pix_out_t exp_px;
    if (!rst_ni) begin
      cur_mode <= MODE_SHADE;
      fail_cnt = 0;
    end else begin
      if (result_valid_o) begin
        if (pixel_q.size() == 0) begin
          $error("unexpected result transfer %h", pix_o);
          fail_cnt++;
        end else begin
          exp_px = pixel_q.pop_front();
          if (pix_o.out_red !== exp_px.out_red) begin
            $error("out_red exp %0d got %0d", exp_px.out_red, pix_o.out_red);
            fail_cnt++;
          end
          if (pix_o.out_green !== exp_px.out_green) begin
            $error("out_green exp %0d got %0d", exp_px.out_green, pix_o.out_green);
            fail_cnt++;
          end
          if (pix_o.out_blue !== exp_px.out_blue) begin
            $error("out_blue exp %0d got %0d", exp_px.out_blue, pix_o.out_blue);
            fail_cnt++;
          end
          if (pix_o.out_alpha !== exp_px.out_alpha) begin
            $error("out_alpha exp %0d got %0d", exp_px.out_alpha, pix_o.out_alpha);
            fail_cnt++;
          end
        end
      end
      if (start && !busy) pixel_q.insert(pixel_q.size(), shade_pixel(pix_i, cur_mode));
      if (cfg_we_i) cur_mode <= mode_e'(cfg_wdata_i);
    end
  end

endmodule

// ----- tb/hsb_shade_adjust_pixel_tb.sv -----
// Testbench top for hsb_shade_adjust_pixel: drives pixels and mode writes, gives the verdict.
// Depends on hsb_pkg, the block and hsb_shade_adjust_pixel_chk.
`timescale 1ns / 1ps

module hsb_shade_adjust_pixel_tb;
  import hsb_pkg::*;

  localparam int RAND_PIXELS = 2000;
  localparam int STALL_LIMIT = 2000;   // idle cycles with no transfer before giving up

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  pix_in_t            pix_i = '0;
  logic               cfg_we_i = 1'b0;
  logic [MODE_W-1:0]  cfg_wdata_i = '0;
  logic               result_valid_o;
  pix_out_t           pix_o;
  int                 fail_cnt;
  int                 pending_cnt;
  int                 idle_cycles = 0;

  always #6 clk_i = ~clk_i;

  hsb_shade_adjust_pixel i_dut (
    .clk_i, .rst_ni, .start, .busy, .pix_i,
    .cfg_we_i, .cfg_wdata_i, .result_valid_o, .pix_o
  );

  hsb_shade_adjust_pixel_chk i_chk (
    .clk_i, .rst_ni, .start, .busy, .pix_i, .cfg_we_i, .cfg_wdata_i,
    .result_valid_o, .pix_o, .fail_cnt, .pending_cnt
  );

  // Watchdog: any cycle without a transfer counts towards the limit.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // One pixel transfer; optional random gap first (about 21 in 100).
  task automatic send_pixel(pix_in_t px, bit gaps);
    if (gaps) begin
      while ($urandom_range(99) < 21) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
    end
    start <= 1'b1;
    pix_i <= px;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Mode change only once the pipe has drained.
  task automatic set_mode(mode_e md);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 2) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= md;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic pix_in_t rand_pixel();
    pix_in_t px;
    px.in_red   = CH_W'($urandom);
    px.in_green = CH_W'($urandom);
    px.in_blue  = CH_W'($urandom);
    px.in_alpha = CH_W'($urandom);
    case ($urandom_range(9))
      0:       px.amount = AMT_W'($urandom);          // includes over-range amounts
      1:       px.amount = AMT_ONE;
      2:       px.amount = '0;
      3: begin
        px.in_green = px.in_red;                        // grey
        px.in_blue  = px.in_red;
        px.amount   = AMT_W'($urandom_range(256));
      end
      default: px.amount = AMT_W'($urandom_range(256));
    endcase
    return px;
  endfunction

  initial begin
    pix_in_t px;
    mode_e   md;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every mode against black, white, grey, primaries and ties, all amount edges.
    for (int m = 0; m < 8; m++) begin
      set_mode(mode_e'(m));
      send_pixel('{8'd0,   8'd0,   8'd0,   8'd0,   9'd128}, 1'b0);
      send_pixel('{8'd255, 8'd255, 8'd255, 8'd255, 9'd256}, 1'b0);
      send_pixel('{8'd128, 8'd128, 8'd128, 8'd17,  9'd511}, 1'b0);
      send_pixel('{8'd255, 8'd0,   8'd0,   8'd1,   9'd0},   1'b0);
      send_pixel('{8'd0,   8'd255, 8'd0,   8'd2,   9'd64},  1'b0);
      send_pixel('{8'd0,   8'd0,   8'd255, 8'd3,   9'd257}, 1'b0);
      send_pixel('{8'd255, 8'd255, 8'd10,  8'd4,   9'd200}, 1'b0);
      send_pixel('{8'd200, 8'd10,  8'd200, 8'd5,   9'd256}, 1'b0);
      send_pixel('{8'd255, 8'd3,   8'd9,   8'd6,   9'd1},   1'b0);
    end

    // Random: phases of random modes, extremes first and last; first phase has no gaps.
    for (int ph = 0; ph < 10; ph++) begin
      md = (ph == 0) ? MODE_SHADE : (ph == 9) ? MODE_ANALOGOUS : mode_e'($urandom_range(7));
      set_mode(md);
      for (int i = 0; i < RAND_PIXELS / 10; i++) begin
        px = rand_pixel();
        send_pixel(px, ph != 0);
      end
    end
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 4) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/hsb_pkg.sv
rtl/hsb_div.sv
rtl/hsb_adjust.sv
rtl/hsb_hsv2rgb.sv
rtl/hsb_shade_adjust_pixel.sv
tb/hsb_shade_adjust_pixel_chk.sv
tb/hsb_shade_adjust_pixel_tb.sv
